[rtl/bq_pkg.sv]
package bq_pkg;

    // Sample and coefficient formats.
    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 16;
    // Q3.F coefficients: sign, three integer bits, F fraction bits.
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 4;
    localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
    // Five products need three guard bits.
    localparam int ACC_WIDTH      = PROD_WIDTH + 3;
    localparam int SCALED_WIDTH   = ACC_WIDTH - COEF_FRAC_BITS;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;

    // Unity gain for b0 after reset.
    localparam coef_t COEF_ONE = coef_t'(1 << COEF_FRAC_BITS);

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Register map of the configuration port.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_index_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coefs_t;

    typedef struct packed {
        sample_t x;
        sample_t x1;
        sample_t x2;
        sample_t y1;
        sample_t y2;
    } taps_t;

    typedef struct packed {
        sample_t sample;
        logic    clipped;
    } result_t;

endpackage

[rtl/bq_mac.sv]
module bq_mac (
    input  bq_pkg::coefs_t  coefs,
    input  bq_pkg::taps_t   taps,
    output bq_pkg::result_t result
);

    logic signed [bq_pkg::PROD_WIDTH-1:0]   prod_b0;
    logic signed [bq_pkg::PROD_WIDTH-1:0]   prod_b1;
    logic signed [bq_pkg::PROD_WIDTH-1:0]   prod_b2;
    logic signed [bq_pkg::PROD_WIDTH-1:0]   prod_a1;
    logic signed [bq_pkg::PROD_WIDTH-1:0]   prod_a2;
    logic signed [bq_pkg::ACC_WIDTH-1:0]    acc;
    logic signed [bq_pkg::SCALED_WIDTH-1:0] scaled;
    logic                                   over_pos;
    logic                                   over_neg;

    // The five tap products, exact.
    assign prod_b0 = coefs.b0 * taps.x;
    assign prod_b1 = coefs.b1 * taps.x1;
    assign prod_b2 = coefs.b2 * taps.x2;
    assign prod_a1 = coefs.a1 * taps.y1;
    assign prod_a2 = coefs.a2 * taps.y2;

    // Exact sum; feedback terms are subtracted.
    assign acc = bq_pkg::ACC_WIDTH'(prod_b0) + bq_pkg::ACC_WIDTH'(prod_b1)
               + bq_pkg::ACC_WIDTH'(prod_b2) - bq_pkg::ACC_WIDTH'(prod_a1)
               - bq_pkg::ACC_WIDTH'(prod_a2);

    // Dropping the fraction bits of a two's complement value floors it.
    assign scaled = $signed(acc[bq_pkg::ACC_WIDTH-1:bq_pkg::COEF_FRAC_BITS]);

    // Out of range when the bits above the sample's sign are not all copies of it.
    assign over_pos = !scaled[bq_pkg::SCALED_WIDTH-1] &&
                      (|scaled[bq_pkg::SCALED_WIDTH-2:bq_pkg::SAMPLE_WIDTH-1]);
    assign over_neg = scaled[bq_pkg::SCALED_WIDTH-1] &&
                      !(&scaled[bq_pkg::SCALED_WIDTH-2:bq_pkg::SAMPLE_WIDTH-1]);

    // Saturate to the sample range.
    always_comb
    begin
        result.clipped = over_pos || over_neg;
        if (over_pos)
        begin
            result.sample = bq_pkg::SAMPLE_MAX;
        end
        else if (over_neg)
        begin
            result.sample = bq_pkg::SAMPLE_MIN;
        end
        else
        begin
            result.sample = scaled[bq_pkg::SAMPLE_WIDTH-1:0];
        end
    end

endmodule

[rtl/biquad_iir_filter_unit.sv]
// Second-order Direct Form I IIR section: each input beat carries one signed
// 24-bit sample and yields one output beat with the filtered, saturated sample
// and a clipped flag. It takes one sample every clock cycle while the output is not
// stalled, and a sample passes through the input register, then the result register;
// the rate is set by the feedback from the last output, which passes combinationally
// through the five multiplies, the sum and the saturation. The Q3.16 coefficients
// b0, b1, b2, a1, a2 (indexes 0 to 4, already divided by a0) are written on the
// configuration port, which is always ready; writes to other indexes are
// dropped. After reset b0 is 1.0, the other taps are zero and all history is
// cleared. Coefficients should only be changed while no sample is in flight.
module biquad_iir_filter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [bq_pkg::SAMPLE_WIDTH-1:0] sample_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [bq_pkg::SAMPLE_WIDTH-1:0] sample_out,
    output logic                               clipped,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bq_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [bq_pkg::COEF_WIDTH-1:0]      cfg_data
);

    bq_pkg::coefs_t  coefs_reg;
    bq_pkg::coefs_t  coefs_next;
    bq_pkg::sample_t x1_reg;
    bq_pkg::sample_t x2_reg;
    bq_pkg::sample_t y1_reg;
    bq_pkg::sample_t y2_reg;
    bq_pkg::sample_t stage_sample_reg;
    logic            stage_valid_reg;
    logic            out_valid_reg;
    bq_pkg::sample_t sample_out_reg;
    logic            clipped_reg;
    bq_pkg::taps_t   taps;
    bq_pkg::result_t result;
    logic            out_load;
    logic            advance;
    logic            in_take;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        coefs_next = coefs_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bq_pkg::REG_B0: coefs_next.b0 = cfg_data;
                bq_pkg::REG_B1: coefs_next.b1 = cfg_data;
                bq_pkg::REG_B2: coefs_next.b2 = cfg_data;
                bq_pkg::REG_A1: coefs_next.a1 = cfg_data;
                bq_pkg::REG_A2: coefs_next.a2 = cfg_data;
                default:        coefs_next = coefs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.b0 <= bq_pkg::COEF_ONE;
            coefs_reg.b1 <= '0;
            coefs_reg.b2 <= '0;
            coefs_reg.a1 <= '0;
            coefs_reg.a2 <= '0;
        end
        else
        begin
            coefs_reg <= coefs_next;
        end
    end

    // Handshake: the result register loads when empty or being drained.
    assign out_load = !out_valid_reg || !out_stall;
    assign advance  = stage_valid_reg && out_load;
    assign in_stall = stage_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_take || advance)
        begin
            stage_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_sample_reg <= sample_in;
        end
    end

    // Multiply-accumulate and saturation.
    assign taps.x  = stage_sample_reg;
    assign taps.x1 = x1_reg;
    assign taps.x2 = x2_reg;
    assign taps.y1 = y1_reg;
    assign taps.y2 = y2_reg;

    bq_mac u_mac (
        .coefs  (coefs_reg),
        .taps   (taps),
        .result (result)
    );

    // History moves on when a sample's result is captured.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (advance)
        begin
            x1_reg <= stage_sample_reg;
            x2_reg <= x1_reg;
            y1_reg <= result.sample;
            y2_reg <= y1_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_out_reg <= result.sample;
            clipped_reg    <= result.clipped;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

`ifndef SYNTH
    // A saturated result sits at one end of the sample range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (sample_out == bq_pkg::SAMPLE_MAX) || (sample_out == bq_pkg::SAMPLE_MIN))
        else $error("clipped result not at a range limit");

    // The newest output history always matches the result just captured.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (y1_reg == sample_out) && (y2_reg == $past(y1_reg)))
        else $error("output history out of step with result");

    // The input history takes the sample that was just processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> x1_reg == $past(stage_sample_reg))
        else $error("input history out of step");

    // Backpressure only while a sample is held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> stage_valid_reg && out_valid_reg)
        else $error("stall without a held sample");
`endif

endmodule
